// File: src/upd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character constants and hex helpers for the percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
	localparam int SLOTS          = 3;

	// Configuration register indexes
	localparam logic REG_FORM_MODE    = 1'b0;
	localparam logic REG_OUT_CAPACITY = 1'b1;

	localparam logic [15:0] CAPACITY_RESET = 16'd1023;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_W       = 8'h57;

	// One accepted item's worth of results: up to three bytes and an end marker.
	typedef struct packed {
		logic [SLOTS-1:0][7:0] bytes;
		logic [1:0]            nbytes;
		logic                  marker;
		logic [15:0]           base_count;
	} upd_bundle_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - CH_ZERO;
		end else begin
			d = (c | 8'h20) - CH_W;
		end
		return d[3:0];
	endfunction

endpackage

// File: src/upd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_front
// Accepts source bytes, tracks escape state, applies the capacity limit and
// writes a result bundle into the queue for each item with results or an end.
// ----------------------------------------------------------------------------
module upd_front import upd_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              q_full,
	output logic              q_wr,
	output upd_bundle_t       q_wdata
);

	localparam int CW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PCT  = 2'd1,
		PH_DIG  = 2'd2
	} phase_t;

	phase_t                phase_q, ph_n;
	logic [7:0]            fd_q, fd_n;
	logic [COUNT_BITS-1:0] count_q;
	logic                  form_q;
	logic [15:0]           cap_q;

	logic [SLOTS-1:0][7:0] cb;
	logic [1:0]            n;
	logic                  idle;
	logic                  accept;
	logic [CW-1:0]         cnt_w, cap_w, max_w, cap_eff;
	logic [SLOTS-1:0]      keep;
	logic [1:0]            k;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cb   = '0;
		n    = 2'd0;
		idle = 1'b0;
		ph_n = phase_q;
		fd_n = fd_q;
		unique case (phase_q)
			PH_PCT: begin
				if (is_hex(in_byte)) begin
					fd_n = in_byte;
					ph_n = PH_DIG;
				end else begin
					cb[n] = CH_PERCENT;
					n     = n + 2'd1;
					idle  = 1'b1;
				end
			end
			PH_DIG: begin
				if (is_hex(in_byte)) begin
					cb[n] = {hex_val(fd_q), hex_val(in_byte)};
					n     = n + 2'd1;
					ph_n  = PH_IDLE;
				end else begin
					cb[n] = CH_PERCENT;
					n     = n + 2'd1;
					cb[n] = fd_q;
					n     = n + 2'd1;
					idle  = 1'b1;
				end
			end
			default: idle = 1'b1;
		endcase
		if (idle) begin
			if (in_byte == CH_PERCENT) begin
				ph_n = PH_PCT;
			end else begin
				cb[n] = (form_q && in_byte == CH_PLUS) ? CH_SPACE : in_byte;
				n     = n + 2'd1;
				ph_n  = PH_IDLE;
			end
		end
		// At the end of the string a pending escape is passed through literally.
		if (in_last) begin
			if (ph_n == PH_PCT) begin
				cb[n] = CH_PERCENT;
				n     = n + 2'd1;
			end else if (ph_n == PH_DIG) begin
				cb[n] = CH_PERCENT;
				n     = n + 2'd1;
				cb[n] = fd_n;
				n     = n + 2'd1;
			end
		end
	end

	// Capacity is the smaller of the register and the counter's full value.
	always_comb begin
		cnt_w   = CW'(count_q);
		cap_w   = CW'(cap_q);
		max_w   = {{(CW-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};
		cap_eff = (cap_w < max_w) ? cap_w : max_w;
		for (int i = 0; i < SLOTS; i++) begin
			keep[i] = (2'(i) < n) && ((cnt_w + CW'(i)) < cap_eff);
		end
		k = keep[2] ? 2'd3 : (keep[1] ? 2'd2 : (keep[0] ? 2'd1 : 2'd0));
	end

	always_comb begin
		q_wdata.bytes      = cb;
		q_wdata.nbytes     = k;
		q_wdata.marker     = in_last;
		q_wdata.base_count = cnt_w[15:0];
		q_wr               = accept && (in_last || k != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fd_q    <= 8'h00;
			count_q <= '0;
			form_q  <= 1'b0;
			cap_q   <= CAPACITY_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FORM_MODE:    form_q <= cfg_data[0];
					REG_OUT_CAPACITY: cap_q  <= cfg_data;
					default:          ;
				endcase
			end
			if (accept) begin
				if (in_last) begin
					phase_q <= PH_IDLE;
					fd_q    <= 8'h00;
					count_q <= '0;
				end else begin
					phase_q <= ph_n;
					fd_q    <= fd_n;
					count_q <= count_q + COUNT_BITS'(k);
				end
			end
		end
	end

endmodule

// File: src/upd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_queue
// Short first-in first-out queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module upd_queue import upd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr,
	input  upd_bundle_t wdata,
	output logic        full,
	output logic        rd_valid,
	output upd_bundle_t rdata,
	input  logic        pop
);

	upd_bundle_t         mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wp_q, rp_q;
	logic [QUEUE_AW:0]   cnt_q;
	logic                do_pop;

	assign full     = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rdata    = mem_q[rp_q];
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (QUEUE_AW+1)'(wr && !full) - (QUEUE_AW+1)'(do_pop);
		end
	end

endmodule

// File: src/upd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_back
// Unpacks bundles into the output register, one result per unstalled cycle.
// ----------------------------------------------------------------------------
module upd_back import upd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  upd_bundle_t q_data,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        has_byte,
	output logic        end_of_string,
	output logic [15:0] byte_count
);

	logic [1:0]  idx_q;
	logic [2:0]  total;
	logic        load;
	logic        is_byte;
	logic        valid_q;

	assign total   = {1'b0, q_data.nbytes} + {2'b00, q_data.marker};
	assign load    = q_valid && (!valid_q || out_ready);
	assign is_byte = (idx_q < q_data.nbytes);
	assign q_pop   = load && ({1'b0, idx_q} == total - 3'd1);
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= q_pop ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (is_byte) begin
				out_byte      <= q_data.bytes[idx_q];
				has_byte      <= 1'b1;
				end_of_string <= 1'b0;
				byte_count    <= q_data.base_count + 16'(idx_q) + 16'd1;
			end else begin
				out_byte      <= 8'h00;
				has_byte      <= 1'b0;
				end_of_string <= 1'b1;
				byte_count    <= q_data.base_count + 16'(q_data.nbytes);
			end
		end
	end

endmodule

// File: src/url_percent_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming percent-decoder with form mode, output capacity and end marker.
// ----------------------------------------------------------------------------
// The first result of an item goes through the four-entry queue between front
// and back, then into the output register. The front accepts one item per
// cycle unless the queue is full; the back sends one result per cycle unless
// stalled, holding the back end until all results of an item have gone out.
// Reset clears escape state, byte count, queue and output valid, and sets
// form_mode to 0 and out_capacity to 1023.
module url_percent_decoder import upd_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        has_byte,
	output logic        end_of_string,
	output logic [15:0] byte_count,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	upd_bundle_t wdata, rdata;
	logic        q_wr, q_full, q_valid, q_pop;

	upd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_byte(in_byte), .in_last(in_last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.q_full(q_full), .q_wr(q_wr), .q_wdata(wdata)
	);

	upd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr(q_wr), .wdata(wdata), .full(q_full),
		.rd_valid(q_valid), .rdata(rdata), .pop(q_pop)
	);

	upd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_data(rdata), .q_pop(q_pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_byte(out_byte), .has_byte(has_byte),
		.end_of_string(end_of_string), .byte_count(byte_count)
	);

endmodule

// File: tb/sv/url_percent_decoder_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_chk
// Watches the input, output and register ports of the percent decoder, keeps
// its own decoder state and register copies, and compares every result item
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module url_percent_decoder_chk import upd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  logic        has_byte,
	input  logic        end_of_string,
	input  logic [15:0] byte_count,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          backlog,
	output int          results_checked,
	output int          strings_closed
);

	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam int         REPORT_LINES = 20;

	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_PERCENT,
		ESC_DIGIT
	} esc_phase_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        has;
		logic        eos;
		logic [15:0] count;
	} decoded_t;

	logic       form_plus;
	logic [15:0] keep_limit;
	esc_phase_t esc;
	logic [7:0] held_digit;
	logic [15:0] kept;
	decoded_t   decoded_q[$];

	// Returns 1 for a hex digit of either case and gives its value in v.
	function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
		logic [7:0] folded;
		folded = c | 8'h20;
		v = (c <= CH_NINE) ? c[3:0] : c[3:0] + 4'd9;
		return (c >= CH_ZERO && c <= CH_NINE) ||
			(folded >= CH_LOWER_A && folded <= CH_LOWER_F);
	endfunction

	// Bytes past the capacity are dropped and do not advance the count.
	task automatic keep_byte(input logic [7:0] b);
		if (kept < keep_limit) begin
			kept++;
			decoded_q.push_back('{data: b, has: 1'b1, eos: 1'b0, count: kept});
		end
	endtask

	task automatic plain_byte(input logic [7:0] b);
		if (b == CH_PERCENT) begin
			esc = ESC_PERCENT;
		end else if (form_plus && b == CH_PLUS) begin
			keep_byte(CH_SPACE);
		end else begin
			keep_byte(b);
		end
	endtask

	task automatic decode_item(input logic [7:0] b, input logic last);
		logic [3:0] lo;
		logic [3:0] hi;
		logic       is_digit;
		is_digit = hex_digit(b, lo);
		case (esc)
			ESC_PERCENT: begin
				if (is_digit) begin
					held_digit = b;
					esc = ESC_DIGIT;
				end else begin
					keep_byte(CH_PERCENT);
					esc = ESC_NONE;
					plain_byte(b);
				end
			end
			ESC_DIGIT: begin
				if (is_digit) begin
					void'(hex_digit(held_digit, hi));
					keep_byte({hi, lo});
					esc = ESC_NONE;
				end else begin
					keep_byte(CH_PERCENT);
					keep_byte(held_digit);
					esc = ESC_NONE;
					plain_byte(b);
				end
			end
			default: begin
				plain_byte(b);
			end
		endcase
		if (last) begin
			// An escape cut short by the end of the string goes out literally.
			if (esc == ESC_PERCENT) begin
				keep_byte(CH_PERCENT);
			end else if (esc == ESC_DIGIT) begin
				keep_byte(CH_PERCENT);
				keep_byte(held_digit);
			end
			decoded_q.push_back('{data: 8'h00, has: 1'b0, eos: 1'b1, count: kept});
			esc = ESC_NONE;
			held_digit = 8'h00;
			kept = 16'd0;
		end
	endtask

	task automatic report_mismatch(input string msg);
		if (mismatches < REPORT_LINES) begin
			$display("%0t ns: result %0d: %s", $time, results_checked, msg);
		end
		mismatches++;
	endtask

	always @(posedge clk) begin : monitor
		decoded_t want;
		if (!arst_n) begin
			form_plus = 1'b0;
			keep_limit = CAPACITY_RESET;
			esc = ESC_NONE;
			held_digit = 8'h00;
			kept = 16'd0;
			decoded_q.delete();
			mismatches = 0;
			backlog = 0;
			results_checked = 0;
			strings_closed = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FORM_MODE) begin
					form_plus = cfg_data[0];
				end else begin
					keep_limit = cfg_data;
				end
			end
			if (in_valid && in_ready) begin
				decode_item(in_byte, in_last);
			end
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					report_mismatch($sformatf("unexpected item byte 0x%02h end %0b",
						out_byte, end_of_string));
				end else begin
					want = decoded_q.pop_front();
					if (out_byte != want.data)
						report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
							out_byte, want.data));
					if (has_byte != want.has)
						report_mismatch($sformatf("has_byte %0b, expected %0b",
							has_byte, want.has));
					if (end_of_string != want.eos)
						report_mismatch($sformatf("end_of_string %0b, expected %0b",
							end_of_string, want.eos));
					if (byte_count != want.count)
						report_mismatch($sformatf("byte_count %0d, expected %0d",
							byte_count, want.count));
				end
				results_checked++;
				if (end_of_string) begin
					strings_closed++;
				end
			end
			backlog = decoded_q.size();
		end
	end

endmodule

// File: tb/sv/url_percent_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_tb
// Drives encoded strings into the percent decoder under several register
// settings: a short directed set of escapes and edge cases, then random
// strings of mostly plain bytes and well-formed escapes with broken ones mixed
// in, with random gaps at the input and random stalls at the output.
// ----------------------------------------------------------------------------
module url_percent_decoder_tb;
	import upd_pkg::*;

	localparam int RANDOM_PHASES   = 7;
	localparam int QUIET_PHASE     = 5;
	localparam int ITEMS_PER_PHASE = 54;
	localparam int DRAIN_CYCLES    = 8;
	localparam int STALL_LIMIT     = 2000;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	// Register words per random phase; the 16'hFFFE form word checks that only
	// bit 0 of form_mode counts.
	localparam logic [15:0] FORM_WORD [RANDOM_PHASES] =
		'{16'h0001, 16'h0000, 16'h0001, 16'hFFFE, 16'h0001, 16'h0000, 16'h0001};
	localparam logic [15:0] CAP_WORD [RANDOM_PHASES] =
		'{16'hFFFF, 16'h0000, 16'h0003, 16'h0001, 16'h0002, 16'h03FF, 16'h0007};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'h00;
	logic        in_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        has_byte;
	logic        end_of_string;
	logic [15:0] byte_count;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_FORM_MODE;
	logic [15:0] cfg_data = 16'h0000;

	int mismatches;
	int backlog;
	int results_checked;
	int strings_closed;
	int items_sent = 0;
	int settings_used = 1;
	int stall_cycles = 0;
	bit quiet = 1'b0;

	url_percent_decoder i_dut (.*);

	url_percent_decoder_chk i_chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 24);
	end

	// Ends the run when neither channel moves an item for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("no item moved for %0d cycles", STALL_LIMIT);
				$display("url_percent_decoder verification failed");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic last);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_item(s[i], i == s.len() - 1);
		end
	endtask

	function automatic logic [7:0] rand_hex();
		logic [3:0] v;
		v = 4'($urandom);
		if (v < 4'd10) begin
			return CH_ZERO + v;
		end
		return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + (v - 4'd10);
	endfunction

	// Mostly well-formed escapes and plain bytes, with broken escapes mixed in.
	task automatic send_random_string();
		logic [7:0] text[$];
		int         tokens;
		int         kind;
		logic [7:0] b;
		tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
		repeat (tokens) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				b = 8'($urandom_range(0, 255));
				text.push_back(b == CH_PERCENT ? CH_PLUS : b);
			end else if (kind < 65) begin
				text.push_back(CH_PERCENT);
				text.push_back(rand_hex());
				text.push_back(rand_hex());
			end else if (kind < 75) begin
				text.push_back(CH_PLUS);
			end else if (kind < 85) begin
				text.push_back(CH_PERCENT);
				text.push_back(8'($urandom_range(0, 255)));
			end else if (kind < 93) begin
				text.push_back(CH_PERCENT);
				text.push_back(rand_hex());
				text.push_back(8'($urandom_range(0, 255)));
			end else begin
				text.push_back(CH_PERCENT);
			end
		end
		foreach (text[i]) begin
			send_item(text[i], i == text.size() - 1);
		end
	endtask

	// An item without results may still be in flight once the backlog is empty.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (backlog != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_regs(input logic [15:0] form_word, input logic [15:0] cap_word);
		cfg_we <= 1'b1;
		cfg_index <= REG_FORM_MODE;
		cfg_data <= form_word;
		@(negedge clk);
		cfg_index <= REG_OUT_CAPACITY;
		cfg_data <= cap_word;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin : stimulus
		int phase_end;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: plain mode, capacity 1023.
		send_text("%41%6a%Fe");
		send_text("a+%4G");
		send_text("%%2");
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_text("%");
		drain();
		set_regs(16'h0001, CAPACITY_RESET);
		send_text("+%2b");

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			set_regs(FORM_WORD[p], CAP_WORD[p]);
			quiet = (p == QUIET_PHASE);
			phase_end = items_sent + ITEMS_PER_PHASE;
			while (items_sent < phase_end) begin
				send_random_string();
			end
		end
		quiet = 1'b0;
		drain();

		$display("Covered %0d source bytes in %0d strings over %0d register settings,",
			items_sent, strings_closed, settings_used);
		$display("with %0d result items checked and %0d mismatches.",
			results_checked, mismatches);
		if (mismatches == 0 && backlog == 0) begin
			$display("url_percent_decoder verification clean");
		end else begin
			$display("url_percent_decoder verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
src/upd_pkg.sv
src/upd_front.sv
src/upd_queue.sv
src/upd_back.sv
src/url_percent_decoder.sv
tb/sv/url_percent_decoder_chk.sv
tb/sv/url_percent_decoder_tb.sv
